// ===== hw/rtl/aavr_pkg.sv =====
// aavr_pkg: shared types, constants and helper functions of the axis-angle
// vector rotation unit (root, divider and series cells, matrix stages).
// No dependencies.
package aavr_pkg;

  // q2.30 unit and pi in the same scale
  localparam logic [31:0] Q_ONE  = 32'h4000_0000;
  localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;

  // output saturation limits
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // cell counts of the three chains
  localparam int unsigned SQRT_CELLS    = 32;
  localparam int unsigned DIV_CELLS     = 31;
  localparam int unsigned TAYLOR_CELLS  = 23;
  localparam int unsigned TAYLOR_STAGES = 3;

  // pipeline stage numbers, counted in registers after the accept edge
  localparam int unsigned ST_NORM    = 2;
  localparam int unsigned ST_L2      = 4;
  localparam int unsigned ST_ROOT    = ST_L2 + SQRT_CELLS;
  localparam int unsigned ST_DIVIN   = ST_ROOT + 1;
  localparam int unsigned ST_QUOT    = ST_DIVIN + DIV_CELLS;
  localparam int unsigned ST_UNIT    = ST_QUOT + 1;
  localparam int unsigned ST_TAYLOR  = ST_NORM + TAYLOR_STAGES * TAYLOR_CELLS;
  localparam int unsigned ST_SINCOS  = ST_TAYLOR + 1;
  localparam int unsigned U_DLY      = ST_SINCOS - ST_UNIT;
  localparam int unsigned ST_MAT     = ST_SINCOS + 3;
  localparam int unsigned PIPE_DEPTH = ST_MAT + 2;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  // square root cell data
  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_cell_t;

  // divider cell data, three lanes share one divisor
  typedef struct packed {
    logic [2:0][63:0] r;
    logic [63:0]      d;
    logic [2:0][30:0] q;
  } div_cell_t;

  // series cell data
  typedef struct packed {
    logic [31:0]        t;
    logic [30:0]        x;
    logic signed [33:0] s;
    logic signed [33:0] c;
  } taylor_t;

  // per-cell series constants
  typedef struct packed {
    logic [4:0]  k;
    logic [31:0] recip;
    logic        to_sin;
    logic        sub;
  } tcoef_t;

  // data that rides alongside the chains
  typedef struct packed {
    logic [2:0][31:0] vec;
    logic [2:0][31:0] m;
    logic [2:0]       neg;
    logic             zero;
    quad_e            quad;
  } side_t;

  // floor(2^32 / k) for k = 2 .. 24
  localparam logic [31:0] RECIP [TAYLOR_CELLS] = '{
    32'h8000_0000, 32'h5555_5555, 32'h4000_0000, 32'h3333_3333,
    32'h2AAA_AAAA, 32'h2492_4924, 32'h2000_0000, 32'h1C71_C71C,
    32'h1999_9999, 32'h1745_D174, 32'h1555_5555, 32'h13B1_3B13,
    32'h1249_2492, 32'h1111_1111, 32'h1000_0000, 32'h0F0F_0F0F,
    32'h0E38_E38E, 32'h0D79_435E, 32'h0CCC_CCCC, 32'h0C30_C30C,
    32'h0BA2_E8BA, 32'h0B21_642C, 32'h0AAA_AAAA
  };

  // constants of series cell idx, which produces term k = idx + 2
  function automatic tcoef_t taylor_coef(input logic [4:0] idx);
    tcoef_t cf;
    logic [4:0] k;
    k         = idx + 5'd2;
    cf.k      = k;
    cf.recip  = RECIP[idx];
    cf.to_sin = k[0];
    cf.sub    = k[1];
    return cf;
  endfunction

  // q2.30 product, half rounded away from zero; magnitudes below 2^32
  function automatic logic signed [34:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic [32:0] ma;
    logic [32:0] mb;
    logic [63:0] p;
    logic [33:0] r;
    ma = a[32] ? 33'(-a) : 33'(a);
    mb = b[32] ? 33'(-b) : 33'(b);
    p  = ma[31:0] * mb[31:0];
    r  = 34'((p + 64'd536870912) >> 30);
    return (a[32] ^ b[32]) ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

endpackage

// ===== hw/rtl/axis_angle_vector_rotation_unit.sv =====
// axis_angle_vector_rotation_unit: one word per cycle sustained unless a result word waits; the
// depth is set by the series path: two input stages, 23 three-stage series cells, a sine/cosine
// stage and a five-stage matrix section.
// The 32 square root cells and 31 divider cells run beside it in fewer stages.
// The whole pipeline holds while a result word waits on out_ready_i.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.
// Depends on aavr_pkg, aavr_sqrt_cell, aavr_div_cell, aavr_taylor_cell.
module axis_angle_vector_rotation_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic        [15:0] turn_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o
);

  // pipeline control
  logic                            en;
  logic [aavr_pkg::PIPE_DEPTH:1]   valid_q;

  assign en         = !valid_q[aavr_pkg::PIPE_DEPTH] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = valid_q[aavr_pkg::PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[aavr_pkg::PIPE_DEPTH-1:1], in_valid_i};
    end
  end

  // stage 1: magnitudes, largest magnitude, angle product
  logic [2:0][31:0] axis_in;
  logic [2:0][31:0] mag_d;
  logic [31:0]      mx_d;
  logic [2:0][31:0] mag_q;
  logic [2:0]       neg_q;
  logic [31:0]      mx_q;
  logic [45:0]      ang_prod_q;
  aavr_pkg::quad_e  quad_q;
  logic [2:0][31:0] vec_q;

  assign axis_in = {axis_z_i, axis_y_i, axis_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = axis_in[i][31] ? (~axis_in[i] + 32'd1) : axis_in[i];
    end
    mx_d = mag_d[0];
    if (mag_d[1] > mx_d) mx_d = mag_d[1];
    if (mag_d[2] > mx_d) mx_d = mag_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q      <= mag_d;
      neg_q      <= {axis_z_i[31], axis_y_i[31], axis_x_i[31]};
      mx_q       <= mx_d;
      ang_prod_q <= turn_angle_i[13:0] * aavr_pkg::PI_Q30;
      quad_q     <= aavr_pkg::quad_e'(turn_angle_i[15:14]);
      vec_q      <= {vec_z_i, vec_y_i, vec_x_i};
    end
  end

  // stage 2: normalizing shift of the axis, series argument x
  logic [31:0]         nv;
  logic [4:0]          sh;
  logic [4:0]          step;
  aavr_pkg::side_t     side_d;
  aavr_pkg::side_t     side_q [aavr_pkg::ST_NORM:aavr_pkg::ST_MAT];
  logic [30:0]         x_d;
  aavr_pkg::taylor_t   tay_in_q;

  always_comb begin
    nv = mx_q;
    sh = '0;
    for (int b = 4; b >= 0; b--) begin
      step = 5'(1 << b);
      if (nv < (32'd1 << (5'd31 - step))) begin
        nv = nv << step;
        sh = sh + step;
      end
    end
    side_d.vec  = vec_q;
    for (int i = 0; i < 3; i++) begin
      side_d.m[i] = mag_q[i] << sh;
    end
    side_d.neg  = neg_q;
    side_d.zero = (mx_q == '0);
    side_d.quad = quad_q;
    x_d = 31'((ang_prod_q + 46'd16384) >> 15);
  end

  // sideband line that follows the chains
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[aavr_pkg::ST_NORM] <= side_d;
      for (int k = aavr_pkg::ST_NORM + 1; k <= aavr_pkg::ST_MAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
      tay_in_q.t <= 32'(x_d);
      tay_in_q.x <= x_d;
      tay_in_q.s <= $signed({3'b000, x_d});
      tay_in_q.c <= $signed({2'b00, aavr_pkg::Q_ONE});
    end
  end

  // stages 3 and 4: squared length of the shifted axis
  logic [2:0][63:0] sq_q;
  logic [63:0]      l2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= side_q[aavr_pkg::ST_NORM].m[i] * side_q[aavr_pkg::ST_NORM].m[i];
      end
      l2_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // square root chain
  aavr_pkg::sqrt_cell_t sqrt_s [0:aavr_pkg::SQRT_CELLS];

  assign sqrt_s[0] = {l2_q, 34'd0, 32'd0};

  for (genvar j = 0; j < aavr_pkg::SQRT_CELLS; j++) begin : g_sqrt
    aavr_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sqrt_s[j]),
      .q_o   (sqrt_s[j+1])
    );
  end

  // divider set-up: rounded numerators and shifted divisor
  aavr_pkg::div_cell_t div_s [0:aavr_pkg::DIV_CELLS];
  aavr_pkg::div_cell_t div_in_d;
  aavr_pkg::div_cell_t div_in_q;
  logic [31:0]         root;

  always_comb begin
    root = sqrt_s[aavr_pkg::SQRT_CELLS].root;
    for (int i = 0; i < 3; i++) begin
      div_in_d.r[i] = (64'(side_q[aavr_pkg::ST_ROOT].m[i]) << 30) + 64'(root >> 1);
      div_in_d.q[i] = '0;
    end
    div_in_d.d = 64'(root) << 30;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_in_q <= div_in_d;
    end
  end

  assign div_s[0] = div_in_q;

  for (genvar j = 0; j < aavr_pkg::DIV_CELLS; j++) begin : g_div
    aavr_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (div_s[j]),
      .q_o   (div_s[j+1])
    );
  end

  // unit axis with sign, zero axis becomes the z axis
  logic [2:0][31:0] u_d;
  logic [2:0][31:0] u_q [0:aavr_pkg::U_DLY];
  logic [31:0]      qc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc = {1'b0, div_s[aavr_pkg::DIV_CELLS].q[i]};
      if (qc > aavr_pkg::Q_ONE) qc = aavr_pkg::Q_ONE;
      u_d[i] = side_q[aavr_pkg::ST_QUOT].neg[i] ? (~qc + 32'd1) : qc;
    end
    if (side_q[aavr_pkg::ST_QUOT].zero) begin
      u_d = {aavr_pkg::Q_ONE, 32'd0, 32'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q[0] <= u_d;
      for (int k = 1; k <= aavr_pkg::U_DLY; k++) begin
        u_q[k] <= u_q[k-1];
      end
    end
  end

  // sine and cosine series chain
  aavr_pkg::taylor_t tay_s [0:aavr_pkg::TAYLOR_CELLS];

  assign tay_s[0] = tay_in_q;

  for (genvar j = 0; j < aavr_pkg::TAYLOR_CELLS; j++) begin : g_taylor
    aavr_taylor_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (aavr_pkg::taylor_coef(5'(j))),
      .d_i    (tay_s[j]),
      .q_o    (tay_s[j+1])
    );
  end

  // clamp the sums and fold in the quadrant
  logic signed [33:0] s_acc;
  logic signed [33:0] c_acc;
  logic signed [31:0] s_cl;
  logic signed [31:0] c_cl;
  logic signed [31:0] sn_d;
  logic signed [31:0] cs_d;
  logic signed [31:0] sn_q;
  logic signed [31:0] cs_q;

  always_comb begin
    s_acc = tay_s[aavr_pkg::TAYLOR_CELLS].s;
    c_acc = tay_s[aavr_pkg::TAYLOR_CELLS].c;
    if (s_acc < 0) s_cl = '0;
    else if (s_acc > $signed({2'b00, aavr_pkg::Q_ONE})) s_cl = aavr_pkg::Q_ONE;
    else s_cl = s_acc[31:0];
    if (c_acc < 0) c_cl = '0;
    else if (c_acc > $signed({2'b00, aavr_pkg::Q_ONE})) c_cl = aavr_pkg::Q_ONE;
    else c_cl = c_acc[31:0];
    unique case (side_q[aavr_pkg::ST_TAYLOR].quad)
      aavr_pkg::QUAD_I: begin
        sn_d = s_cl;
        cs_d = c_cl;
      end
      aavr_pkg::QUAD_II: begin
        sn_d = c_cl;
        cs_d = -s_cl;
      end
      aavr_pkg::QUAD_III: begin
        sn_d = -s_cl;
        cs_d = -c_cl;
      end
      default: begin
        sn_d = -c_cl;
        cs_d = s_cl;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_q <= sn_d;
      cs_q <= cs_d;
    end
  end

  // matrix stage 1: axis products and sine terms
  logic signed [31:0] ua [3];
  logic signed [34:0] uu_p [3];
  logic signed [34:0] uij_p [3];
  logic signed [34:0] su_p [3];
  logic signed [31:0] uu1_q [3];
  logic signed [31:0] uij_q [3];
  logic signed [31:0] su1_q [3];
  logic signed [31:0] cs1_q;
  logic signed [32:0] oc_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua[i]   = $signed(u_q[aavr_pkg::U_DLY][i]);
      uu_p[i] = aavr_pkg::mulq(33'(ua[i]), 33'(ua[i]));
      su_p[i] = aavr_pkg::mulq(33'(sn_q), 33'(ua[i]));
    end
    uij_p[0] = aavr_pkg::mulq(33'(ua[0]), 33'(ua[1]));
    uij_p[1] = aavr_pkg::mulq(33'(ua[0]), 33'(ua[2]));
    uij_p[2] = aavr_pkg::mulq(33'(ua[1]), 33'(ua[2]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uu1_q[i] <= uu_p[i][31:0];
        uij_q[i] <= uij_p[i][31:0];
        su1_q[i] <= su_p[i][31:0];
      end
      cs1_q <= cs_q;
      oc_q  <= $signed({1'b0, aavr_pkg::Q_ONE}) - 33'(cs_q);
    end
  end

  // matrix stage 2: cosine terms
  logic signed [34:0] dg_p [3];
  logic signed [34:0] of_p [3];
  logic signed [31:0] dg_q [3];
  logic signed [32:0] of_q [3];
  logic signed [31:0] uu2_q [3];
  logic signed [31:0] su2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dg_p[i] = aavr_pkg::mulq($signed({1'b0, aavr_pkg::Q_ONE}) - 33'(uu1_q[i]),
                               33'(cs1_q));
      of_p[i] = aavr_pkg::mulq(33'(uij_q[i]), oc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dg_q[i]  <= dg_p[i][31:0];
        of_q[i]  <= of_p[i][32:0];
        uu2_q[i] <= uu1_q[i];
        su2_q[i] <= su1_q[i];
      end
    end
  end

  // matrix stage 3: matrix entries
  logic signed [32:0] mat_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mat_q[i][i] <= 33'(uu2_q[i]) + 33'(dg_q[i]);
      end
      mat_q[0][1] <= of_q[0] - 33'(su2_q[2]);
      mat_q[1][0] <= of_q[0] + 33'(su2_q[2]);
      mat_q[0][2] <= of_q[1] + 33'(su2_q[1]);
      mat_q[2][0] <= of_q[1] - 33'(su2_q[1]);
      mat_q[1][2] <= of_q[2] - 33'(su2_q[0]);
      mat_q[2][1] <= of_q[2] + 33'(su2_q[0]);
    end
  end

  // matrix stage 4: entry times vector component
  logic signed [34:0] pr_d [3][3];
  logic signed [34:0] pr_q [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr_d[i][j] = aavr_pkg::mulq(mat_q[i][j],
                                    33'($signed(side_q[aavr_pkg::ST_MAT].vec[j])));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q <= pr_d;
    end
  end

  // output word: row sums with saturation
  logic signed [36:0] acc [3];
  logic [2:0][31:0]   res_d;
  logic [2:0][31:0]   res_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 37'(pr_q[i][0]) + 37'(pr_q[i][1]) + 37'(pr_q[i][2]);
      if (acc[i] > $signed({5'b0, aavr_pkg::SAT_MAX})) res_d[i] = aavr_pkg::SAT_MAX;
      else if (acc[i] < $signed({5'b11111, aavr_pkg::SAT_MIN})) res_d[i] = aavr_pkg::SAT_MIN;
      else res_d[i] = acc[i][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_x_o = $signed(res_q[0]);
  assign out_y_o = $signed(res_q[1]);
  assign out_z_o = $signed(res_q[2]);

  // accepted word enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[1])
    else $error("accepted word did not enter the pipeline");

  // a waiting result freezes every stage
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(valid_q))
    else $error("pipeline moved while the output word was stalled");

  // root of a normalized nonzero axis is at least 2^30
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[aavr_pkg::ST_ROOT] && !side_q[aavr_pkg::ST_ROOT].zero
    |-> sqrt_s[aavr_pkg::SQRT_CELLS].root[31:30] != 2'b00)
    else $error("square root of normalized axis out of range");

  // unit components never exceed one before the clamp
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[aavr_pkg::ST_QUOT] && !side_q[aavr_pkg::ST_QUOT].zero
    |-> ({1'b0, div_s[aavr_pkg::DIV_CELLS].q[0]} <= aavr_pkg::Q_ONE) &&
        ({1'b0, div_s[aavr_pkg::DIV_CELLS].q[1]} <= aavr_pkg::Q_ONE) &&
        ({1'b0, div_s[aavr_pkg::DIV_CELLS].q[2]} <= aavr_pkg::Q_ONE))
    else $error("unit axis quotient above one");

endmodule

// ===== hw/rtl/aavr_sqrt_cell.sv =====
// aavr_sqrt_cell: one step of the digit-by-digit integer square root,
// one result bit per cell. Depends on aavr_pkg.
module aavr_sqrt_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  aavr_pkg::sqrt_cell_t d_i,
  output aavr_pkg::sqrt_cell_t q_o
);

  logic [35:0] r2;
  logic [35:0] trial;
  logic        ge;
  aavr_pkg::sqrt_cell_t cell_d;
  aavr_pkg::sqrt_cell_t cell_q;

  // bring in two radicand bits and try the next root bit
  always_comb begin
    r2          = {d_i.rem, d_i.rad[63:62]};
    trial       = {2'b00, d_i.root, 2'b01};
    ge          = (r2 >= trial);
    cell_d.rad  = d_i.rad << 2;
    cell_d.rem  = ge ? 34'(r2 - trial) : r2[33:0];
    cell_d.root = {d_i.root[30:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== hw/rtl/aavr_div_cell.sv =====
// aavr_div_cell: one restoring division step for three lanes that share a
// divisor, one quotient bit per cell. Depends on aavr_pkg.
module aavr_div_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  aavr_pkg::div_cell_t d_i,
  output aavr_pkg::div_cell_t q_o
);

  aavr_pkg::div_cell_t cell_d;
  aavr_pkg::div_cell_t cell_q;

  // compare each remainder against the shifted divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_i.r[i] >= d_i.d) begin
        cell_d.r[i] = d_i.r[i] - d_i.d;
        cell_d.q[i] = {d_i.q[i][29:0], 1'b1};
      end else begin
        cell_d.r[i] = d_i.r[i];
        cell_d.q[i] = {d_i.q[i][29:0], 1'b0};
      end
    end
    cell_d.d = d_i.d >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== hw/rtl/aavr_taylor_cell.sv =====
// aavr_taylor_cell: one term of the sine/cosine series in three stages:
// multiply by x, multiply by the reciprocal of k, correct and accumulate.
// Depends on aavr_pkg.
module aavr_taylor_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  aavr_pkg::tcoef_t  coef_i,
  input  aavr_pkg::taylor_t d_i,
  output aavr_pkg::taylor_t q_o
);

  // stage a: t * x
  logic [62:0]        prod_a_q;
  logic [30:0]        x_a_q;
  logic signed [33:0] s_a_q;
  logic signed [33:0] c_a_q;

  // stage b: scaled product and its reciprocal product
  logic [31:0]        p_b_d;
  logic [31:0]        p_b_q;
  logic [63:0]        pr_b_q;
  logic [30:0]        x_b_q;
  logic signed [33:0] s_b_q;
  logic signed [33:0] c_b_q;

  // stage c: corrected quotient and sums
  logic [31:0]        q_est;
  logic [36:0]        qk;
  logic [31:0]        rem;
  logic [31:0]        term;
  logic signed [33:0] term_s;
  aavr_pkg::taylor_t  cell_d;
  aavr_pkg::taylor_t  cell_q;

  assign p_b_d = prod_a_q[61:30];

  // quotient estimate is low by at most one
  always_comb begin
    q_est  = pr_b_q[63:32];
    qk     = q_est * coef_i.k;
    rem    = p_b_q - qk[31:0];
    term   = (rem >= 32'(coef_i.k)) ? q_est + 32'd1 : q_est;
    term_s = $signed({2'b00, term});
    cell_d.t = term;
    cell_d.x = x_b_q;
    cell_d.s = s_b_q;
    cell_d.c = c_b_q;
    if (coef_i.to_sin) begin
      cell_d.s = coef_i.sub ? s_b_q - term_s : s_b_q + term_s;
    end else begin
      cell_d.c = coef_i.sub ? c_b_q - term_s : c_b_q + term_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q <= d_i.t * d_i.x;
      x_a_q    <= d_i.x;
      s_a_q    <= d_i.s;
      c_a_q    <= d_i.c;
      p_b_q    <= p_b_d;
      pr_b_q   <= p_b_d * coef_i.recip;
      x_b_q    <= x_a_q;
      s_b_q    <= s_a_q;
      c_b_q    <= c_a_q;
      cell_q   <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== tb/sv/tb_axis_angle_vector_rotation_unit.sv =====
// tb_axis_angle_vector_rotation_unit: self-checking bench for the axis-angle rotation unit,
// a directed table followed by random words, checked against table results or a bit-exact predictor.
// Depends on aavr_pkg and axis_angle_vector_rotation_unit.
`timescale 1ns / 1ps

module tb_axis_angle_vector_rotation_unit;

  localparam int unsigned N_RANDOM   = 1030;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN      = 100;

  typedef struct {
    logic signed [31:0] vx, vy, vz, ax, ay, az;
    logic [15:0]        ang;
  } rot_in_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } rot_out_t;

  typedef struct {
    rot_in_t  w;
    bit       known;
    rot_out_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [31:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic [15:0] turn_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;

  rot_out_t rotated_q[$];
  int unsigned n_err = 0;
  int unsigned n_words = 0;
  int unsigned n_results = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  axis_angle_vector_rotation_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .vec_x_i, .vec_y_i, .vec_z_i, .axis_x_i, .axis_y_i, .axis_z_i, .turn_angle_i,
    .out_valid_o, .out_ready_i, .out_x_o, .out_y_o, .out_z_o
  );

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // q2.30 product, half away from zero
  function automatic longint qmul(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p  = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n  -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  // rotate one word about its normalized axis
  function automatic rot_out_t rotate_word(rot_in_t w);
    longint v[3], a[3], u[3], m[3][3];
    longint unsigned mg[3], mx, s2, q, x, t;
    longint sn, cs, sn0, cs0, oc, acc, one;
    aavr_pkg::quad_e quad;
    rot_out_t r;
    one = longint'(aavr_pkg::Q_ONE);
    v = '{w.vx, w.vy, w.vz};
    a = '{w.ax, w.ay, w.az};
    // unit axis
    for (int i = 0; i < 3; i++) mg[i] = a[i] < 0 ? -a[i] : a[i];
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
    if (mx == 0) begin
      u = '{0, 0, one};
    end else begin
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) mg[i] <<= 1;
      end
      s2 = int_sqrt(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
      for (int i = 0; i < 3; i++) begin
        q = ((mg[i] << 30) + (s2 >> 1)) / s2;
        if (q > aavr_pkg::Q_ONE) q = aavr_pkg::Q_ONE;
        u[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    // sine and cosine by series within the quadrant
    quad = aavr_pkg::quad_e'(w.ang[15:14]);
    x = (longint'(w.ang[13:0]) * aavr_pkg::PI_Q30 + 16384) >> 15;
    t = aavr_pkg::Q_ONE;
    sn0 = 0;
    cs0 = one;
    for (int k = 1; k <= 24; k++) begin
      t = ((t * x) >> 30) / k;
      if (k % 2) begin
        if (((k - 1) >> 1) % 2) sn0 -= t; else sn0 += t;
      end else begin
        if ((k >> 1) % 2) cs0 -= t; else cs0 += t;
      end
    end
    if (sn0 < 0) sn0 = 0;
    if (sn0 > one) sn0 = one;
    if (cs0 < 0) cs0 = 0;
    if (cs0 > one) cs0 = one;
    case (quad)
      aavr_pkg::QUAD_I:   begin sn = sn0;  cs = cs0;  end
      aavr_pkg::QUAD_II:  begin sn = cs0;  cs = -sn0; end
      aavr_pkg::QUAD_III: begin sn = -sn0; cs = -cs0; end
      default:            begin sn = -cs0; cs = sn0;  end
    endcase
    oc = one - cs;
    // rotation matrix
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (i == j) m[i][j] = qmul(u[i], u[i]) + qmul(one - qmul(u[i], u[i]), cs);
        else m[i][j] = qmul(qmul(u[i], u[j]), oc);
    m[0][1] -= qmul(sn, u[2]);
    m[1][0] += qmul(sn, u[2]);
    m[0][2] += qmul(sn, u[1]);
    m[2][0] -= qmul(sn, u[1]);
    m[1][2] -= qmul(sn, u[0]);
    m[2][1] += qmul(sn, u[0]);
    // products and saturation
    for (int i = 0; i < 3; i++) begin
      acc = qmul(m[i][0], v[0]) + qmul(m[i][1], v[1]) + qmul(m[i][2], v[2]);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      case (i)
        0: r.x = acc[31:0];
        1: r.y = acc[31:0];
        default: r.z = acc[31:0];
      endcase
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] exp_v);
    n_err++;
    $display("mismatch result %0d %s: got %h expected %h", n_results, what, got, exp_v);
  endtask

  // result checker
  always @(posedge clk_i) begin
    rot_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rotated_q.size() == 0) begin
        report("unexpected word", out_x_o, '0);
      end else begin
        e = rotated_q.pop_front();
        if (out_x_o !== e.x) report("out_x", out_x_o, e.x);
        if (out_y_o !== e.y) report("out_y", out_y_o, e.y);
        if (out_z_o !== e.z) report("out_z", out_z_o, e.z);
      end
      n_results++;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // valid drops only in idle cycles, so back to back words keep it high
  task automatic send_word(rot_in_t w, bit known, rot_out_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    vec_x_i      <= w.vx;
    vec_y_i      <= w.vy;
    vec_z_i      <= w.vz;
    axis_x_i     <= w.ax;
    axis_y_i     <= w.ay;
    axis_z_i     <= w.az;
    turn_angle_i <= w.ang;
    rotated_q.push_back(known ? r : rotate_word(w));
    do @(posedge clk_i); while (!in_ready_o);
    n_words++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(15);
      3: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(7)
                                  : 32'h7FFF_FFFF - $urandom_range(7);
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  initial begin
    row_t tbl[$];
    rot_in_t w;
    rot_out_t nr;
    nr = '{0, 0, 0};
    // directed rows: identity angle, zero axis, extremes, every quadrant
    tbl.push_back('{'{32'h0001_0000, 32'h0002_0000, -32'sh0003_0000, 0, 0, 32'h0001_0000, 16'h0},
                    1, '{32'h0001_0000, 32'h0002_0000, -32'sh0003_0000}});
    tbl.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                      5, 16'h0}, 1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678}});
    tbl.push_back('{'{32'h0001_0000, 0, 0, 0, 0, 0, 16'h4000}, 0, nr});
    tbl.push_back('{'{32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 16'h8000}, 0, nr});
    tbl.push_back('{'{32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 16'hC000}, 0, nr});
    tbl.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1, 16'h2000}, 0, nr});
    tbl.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -1, 1, -1, 16'h6000}, 0, nr});
    tbl.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 16'hFFFF}, 0, nr});
    tbl.push_back('{'{32'hFFFF_FFFF, 1, 32'h0000_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 16'h0001}, 0, nr});
    tbl.push_back('{'{32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 0, 32'h0002_0000, 0,
                      16'h3FFF}, 0, nr});
    tbl.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000, 16'h2000}, 0, nr});
    tbl.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 3, 4, 0, 16'hBFFF}, 0, nr});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 35;
    recv_idle = 73;
    foreach (tbl[i]) send_word(tbl[i].w, tbl[i].known, tbl[i].r);

    // random words in three idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle = 73;
        recv_idle = 35;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      w.vx  = rand_coord();
      w.vy  = rand_coord();
      w.vz  = rand_coord();
      w.ax  = ($urandom_range(15) == 0) ? 0 : rand_coord();
      w.ay  = ($urandom_range(15) == 0) ? 0 : rand_coord();
      w.az  = ($urandom_range(15) == 0) ? 0 : rand_coord();
      w.ang = ($urandom_range(19) == 0) ? 16'h0 : 16'($urandom);
      send_word(w, 0, nr);
    end
    in_valid_i <= 1'b0;

    // drain
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("sent %0d words, checked %0d results across three stall patterns",
             n_words, n_results);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", n_err);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/aavr_pkg.sv
hw/rtl/aavr_sqrt_cell.sv
hw/rtl/aavr_div_cell.sv
hw/rtl/aavr_taylor_cell.sv
hw/rtl/axis_angle_vector_rotation_unit.sv
tb/sv/tb_axis_angle_vector_rotation_unit.sv
